@@ rtl/awbg_pkg.sv @@
// Shared types and constants for the white-balance gain pipeline.
package awbg_pkg;

    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned NUM_STAGES = 2 * DIV_STEPS + 2;

    localparam logic [15:0] UNITY_GAIN = 16'h0400;
    localparam logic [15:0] TYPICAL_RED_RESET = 16'h0253;
    localparam logic [15:0] TYPICAL_BLUE_RESET = 16'h027F;

    localparam logic CFG_TYPICAL_RED = 1'b0;
    localparam logic CFG_TYPICAL_BLUE = 1'b1;

    typedef enum logic [1:0] {
        FILL_NONE,
        FILL_RED,
        FILL_BLUE
    } fill_t;

    // One restoring-division lane: partial remainder, dividend shifting out
    // at the top while quotient bits shift in at the bottom, and divisor.
    typedef struct packed {
        logic [15:0] rem;
        logic [31:0] nq;
        logic [15:0] den;
    } lane_t;

    typedef struct packed {
        logic [15:0] red_ratio;
        logic [15:0] blue_ratio;
        logic [15:0] typ_red;
        logic [15:0] typ_blue;
        logic        err;
        logic        red_below;
        logic        blue_below;
        logic [15:0] red_gain;
        logic [15:0] green_gain;
        logic [15:0] blue_gain;
        fill_t       fill;
        logic        ovf;
    } side_t;

    typedef struct packed {
        side_t side;
        lane_t lane0;
        lane_t lane1;
    } pipe_t;

endpackage

@@ rtl/awbg_cell.sv @@
// One division step cell: retires one quotient bit on each of two lanes.
module awbg_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  awbg_pkg::pipe_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output awbg_pkg::pipe_t out_data
);

    logic            valid_reg;
    logic            valid_next;
    awbg_pkg::pipe_t data_reg;
    awbg_pkg::pipe_t data_next;

    function automatic awbg_pkg::lane_t step(input awbg_pkg::lane_t l);
        logic [16:0] t;
        logic [16:0] d;
        logic        ge;
        awbg_pkg::lane_t o;
        t = {l.rem, l.nq[31]};
        d = t - {1'b0, l.den};
        ge = (t >= {1'b0, l.den});
        o.rem = ge ? d[15:0] : t[15:0];
        o.nq = {l.nq[30:0], ge};
        o.den = l.den;
        return o;
    endfunction

    assign in_ready = ~valid_reg | out_ready;

    always_comb begin
        valid_next = in_ready ? in_valid : valid_reg;
        data_next = in_data;
        data_next.lane0 = step(in_data.lane0);
        data_next.lane1 = step(in_data.lane1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

@@ rtl/awbg_mid.sv @@
// Middle stage: picks the anchored channel and sets up the second division.
module awbg_mid (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  awbg_pkg::pipe_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output awbg_pkg::pipe_t out_data
);

    logic            valid_reg;
    logic            valid_next;
    awbg_pkg::pipe_t data_reg;
    awbg_pkg::pipe_t data_next;

    logic [15:0] g0;
    logic [15:0] g1;
    logic        hi0;
    logic        hi1;
    logic [15:0] mul_a;
    logic [15:0] mul_b;
    logic [15:0] den;

    assign in_ready = ~valid_reg | out_ready;

    always_comb begin
        g0 = in_data.lane0.nq[15:0];
        g1 = in_data.lane1.nq[15:0];
        hi0 = |in_data.lane0.nq[31:16];
        hi1 = |in_data.lane1.nq[31:16];
        data_next = in_data;
        data_next.side.red_gain = awbg_pkg::UNITY_GAIN;
        data_next.side.green_gain = awbg_pkg::UNITY_GAIN;
        data_next.side.blue_gain = awbg_pkg::UNITY_GAIN;
        data_next.side.fill = awbg_pkg::FILL_NONE;
        data_next.side.ovf = 1'b0;
        if (in_data.side.blue_below && in_data.side.red_below) begin
            data_next.side.blue_gain = g0;
            data_next.side.red_gain = g1;
            data_next.side.ovf = hi0 | hi1;
        end else if (in_data.side.blue_below) begin
            data_next.side.green_gain = g1;
            data_next.side.ovf = hi1;
            data_next.side.fill = awbg_pkg::FILL_BLUE;
        end else if (in_data.side.red_below) begin
            data_next.side.green_gain = g0;
            data_next.side.ovf = hi0;
            data_next.side.fill = awbg_pkg::FILL_RED;
        end else begin
            // Larger green candidate wins; a tie goes to the red anchor.
            data_next.side.ovf = hi0 | hi1;
            if (g0 > g1) begin
                data_next.side.green_gain = g0;
                data_next.side.fill = awbg_pkg::FILL_RED;
            end else begin
                data_next.side.green_gain = g1;
                data_next.side.fill = awbg_pkg::FILL_BLUE;
            end
        end
        mul_a = data_next.side.green_gain;
        case (data_next.side.fill)
            awbg_pkg::FILL_RED: begin
                mul_b = in_data.side.typ_red;
                den = in_data.side.red_ratio;
            end
            awbg_pkg::FILL_BLUE: begin
                mul_b = in_data.side.typ_blue;
                den = in_data.side.blue_ratio;
            end
            default: begin
                mul_b = 16'd0;
                den = 16'd1;
            end
        endcase
        data_next.lane0.rem = 16'd0;
        data_next.lane0.nq = 32'(mul_a) * 32'(mul_b);
        data_next.lane0.den = den;
        data_next.lane1 = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    always_comb begin
        valid_next = in_ready ? in_valid : valid_reg;
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

@@ rtl/sensor_awb_gain_from_ratios.sv @@
// Top level of the white-balance gain calculator: two 32-cell division chains
// joined by a select-and-multiply stage. Every word passes through 32 division
// cells, the middle stage and 32 more cells; the pipeline accepts one word
// per cycle while m_ready does not stall it; each chain retires 32 quotient
// bits, one per cell. A zero measured ratio flags ratio_error with all gains
// and flags zero. The typical ratios are to be written through cfg_wr_en/
// cfg_index/cfg_wdata by the user only while idle; not enforced by the block.
module sensor_awb_gain_from_ratios (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_red_ratio,
    input  logic [15:0] s_blue_ratio,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_red_gain,
    output logic [15:0] m_green_gain,
    output logic [15:0] m_blue_gain,
    output logic        m_red_apply,
    output logic        m_green_apply,
    output logic        m_blue_apply,
    output logic        m_ratio_error,
    output logic        m_gain_overflow
);

    localparam int unsigned LAST = awbg_pkg::NUM_STAGES - 1;

    logic [15:0] typ_red_reg;
    logic [15:0] typ_blue_reg;

    awbg_pkg::pipe_t stage_data [0:LAST];
    logic [LAST:0]   stage_valid;
    logic [LAST:0]   stage_ready;

    awbg_pkg::pipe_t head;
    awbg_pkg::pipe_t tail;
    logic            both_below;
    logic [15:0]     q_low;
    logic            q_high;
    logic [15:0]     r_gain;
    logic [15:0]     g_gain;
    logic [15:0]     b_gain;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            typ_red_reg <= awbg_pkg::TYPICAL_RED_RESET;
            typ_blue_reg <= awbg_pkg::TYPICAL_BLUE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                awbg_pkg::CFG_TYPICAL_RED: typ_red_reg <= cfg_wdata;
                awbg_pkg::CFG_TYPICAL_BLUE: typ_blue_reg <= cfg_wdata;
                default: typ_red_reg <= typ_red_reg;
            endcase
        end
    end

    // The first chain divides both lanes at once; which divisions they carry
    // depends on where the measured ratios sit against the typical ones.
    always_comb begin
        head = '0;
        head.side.red_ratio = s_red_ratio;
        head.side.blue_ratio = s_blue_ratio;
        head.side.typ_red = typ_red_reg;
        head.side.typ_blue = typ_blue_reg;
        head.side.err = (s_red_ratio == 16'd0) || (s_blue_ratio == 16'd0);
        head.side.red_below = s_red_ratio < typ_red_reg;
        head.side.blue_below = s_blue_ratio < typ_blue_reg;
        head.side.fill = awbg_pkg::FILL_NONE;
        both_below = head.side.red_below && head.side.blue_below;
        if (both_below) begin
            head.lane0.nq = {6'd0, typ_blue_reg, 10'd0};
            head.lane0.den = s_blue_ratio;
            head.lane1.nq = {6'd0, typ_red_reg, 10'd0};
            head.lane1.den = s_red_ratio;
        end else begin
            head.lane0.nq = {6'd0, s_blue_ratio, 10'd0};
            head.lane0.den = typ_blue_reg;
            head.lane1.nq = {6'd0, s_red_ratio, 10'd0};
            head.lane1.den = typ_red_reg;
        end
    end

    assign stage_data[0] = head;
    assign stage_valid[0] = s_valid;
    assign s_ready = stage_ready[0];

    genvar k;
    generate
        for (k = 0; k < awbg_pkg::DIV_STEPS; k++) begin : g_first
            awbg_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .in_valid  (stage_valid[k]),
                .in_ready  (stage_ready[k]),
                .in_data   (stage_data[k]),
                .out_valid (stage_valid[k+1]),
                .out_ready (stage_ready[k+1]),
                .out_data  (stage_data[k+1])
            );
        end
    endgenerate

    awbg_mid u_mid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (stage_valid[awbg_pkg::DIV_STEPS]),
        .in_ready  (stage_ready[awbg_pkg::DIV_STEPS]),
        .in_data   (stage_data[awbg_pkg::DIV_STEPS]),
        .out_valid (stage_valid[awbg_pkg::DIV_STEPS+1]),
        .out_ready (stage_ready[awbg_pkg::DIV_STEPS+1]),
        .out_data  (stage_data[awbg_pkg::DIV_STEPS+1])
    );

    generate
        for (k = awbg_pkg::DIV_STEPS + 1; k < LAST; k++) begin : g_second
            awbg_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .in_valid  (stage_valid[k]),
                .in_ready  (stage_ready[k]),
                .in_data   (stage_data[k]),
                .out_valid (stage_valid[k+1]),
                .out_ready (stage_ready[k+1]),
                .out_data  (stage_data[k+1])
            );
        end
    endgenerate

    assign tail = stage_data[LAST];
    assign m_valid = stage_valid[LAST];
    assign stage_ready[LAST] = m_ready;

    always_comb begin
        q_low = tail.lane0.nq[15:0];
        q_high = |tail.lane0.nq[31:16];
        r_gain = tail.side.red_gain;
        g_gain = tail.side.green_gain;
        b_gain = tail.side.blue_gain;
        case (tail.side.fill)
            awbg_pkg::FILL_RED: r_gain = q_low;
            awbg_pkg::FILL_BLUE: b_gain = q_low;
            default: g_gain = tail.side.green_gain;
        endcase
        if (tail.side.err) begin
            m_red_gain = 16'd0;
            m_green_gain = 16'd0;
            m_blue_gain = 16'd0;
            m_gain_overflow = 1'b0;
        end else begin
            m_red_gain = r_gain;
            m_green_gain = g_gain;
            m_blue_gain = b_gain;
            m_gain_overflow = tail.side.ovf
                              | (q_high && (tail.side.fill != awbg_pkg::FILL_NONE));
        end
        m_ratio_error = tail.side.err;
        m_red_apply = m_red_gain > awbg_pkg::UNITY_GAIN;
        m_green_apply = m_green_gain > awbg_pkg::UNITY_GAIN;
        m_blue_apply = m_blue_gain > awbg_pkg::UNITY_GAIN;
    end

endmodule
